/* rtl/lbts_pkg.sv */
package lbts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    localparam int SMP_W   = 10;
    localparam int CNT_W   = 16;
    localparam int SHIFT_K = 6;

    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;
    localparam int APB_AW   = 5;

    localparam logic [2:0] REG_LIGHT_MIN   = 3'd0;
    localparam logic [2:0] REG_LIGHT_MAX   = 3'd1;
    localparam logic [2:0] REG_COUNTS_MAX  = 3'd2;
    localparam logic [2:0] REG_COUNTS_MIN  = 3'd3;
    localparam logic [2:0] REG_AUTO_ENABLE = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CAL    = 1'b1;
    localparam logic CH_THERM  = 1'b0;
    localparam logic CH_LIGHT  = 1'b1;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quotient;
        logic [SMP_W-1:0] remainder;
    } div_res_t;

    function automatic logic [TBL_AW-1:0] table_index(input logic [SMP_W-1:0] smp);
        logic [TBL_AW-1:0] idx;
        if (32'(smp) >= TABLE_DEPTH)
            idx = TBL_AW'(TABLE_DEPTH - 1);
        else
            idx = TBL_AW'(smp);
        return idx;
    endfunction

endpackage

/* rtl/lbts_div.sv */
module lbts_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lbts_pkg::CNT_W-1:0]   dividend,
    input  logic [lbts_pkg::SMP_W-1:0]   divisor,
    output lbts_pkg::div_res_t           res
);
    import lbts_pkg::*;

    localparam int CW = $clog2(CNT_W);

    logic [CNT_W-1:0] quot_reg, quot_next;
    logic [SMP_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SMP_W:0]   trial;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[CNT_W-1]};
        ge        = trial >= {1'b0, divisor};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[CNT_W-2:0], ge};
            rem_next  = ge ? SMP_W'(trial - {1'b0, divisor}) : trial[SMP_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(CNT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign res = {done_reg, quot_reg, rem_reg};

endmodule

/* rtl/light_brightness_table_smoother.sv */
// Sample word: from acceptance straight to the DONE state and the result; auto-brightness light
// sample: one table memory read, then one smoothing step in the TRACK state, then the result.
// Calibrate word: 16-bit shift-subtract divide, then one table write per cycle across all
// TABLE_DEPTH entries, then the result.
// One word in flight; the result register frees the input side once loaded.
// rst_n asynchronous: readings, brightness and config cleared to defaults; table left unset.
module light_brightness_table_smoother (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lbts_pkg::S_DATA_W-1:0]    s_tdata,  // sample[9:0], zero pad
    input  logic [lbts_pkg::S_USER_W-1:0]    s_tuser,  // op, channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lbts_pkg::M_DATA_W-1:0]    m_tdata,  // thermistor_value, light_value,
                                                       // brightness, zero pad
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lbts_pkg::APB_AW-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import lbts_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_TRACK = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;

    logic [SMP_W-1:0]  light_min_reg, light_max_reg;
    logic [CNT_W-1:0]  counts_max_reg, counts_min_reg;
    logic              auto_enable_reg;

    logic [SMP_W-1:0]  therm_reg, light_reg;
    logic [CNT_W-1:0]  bright_reg, bright_next;

    logic              out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic [TBL_AW-1:0] fill_idx_reg;
    logic [CNT_W-1:0]  val_reg, val_next;
    logic [SMP_W-1:0]  err_reg, err_next;

    logic [CNT_W-1:0]  mem [TABLE_DEPTH];
    logic [CNT_W-1:0]  rdata_reg;
    logic              mem_we;
    logic [CNT_W-1:0]  mem_wdata;
    logic              rd_en;

    logic              accept, cfg_wr, out_free, in_range, fill_last;
    logic [2:0]        reg_idx;
    logic [SMP_W-1:0]  range;
    logic [CNT_W-1:0]  step;
    logic [SMP_W-1:0]  rem;
    logic [SMP_W:0]    err_sum;
    logic [CNT_W-1:0]  diff;
    logic              in_op, in_ch;
    logic [SMP_W-1:0]  in_smp;
    div_res_t          div_res;

    assign in_op  = s_tuser[0];
    assign in_ch  = s_tuser[1];
    assign in_smp = s_tdata[SMP_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            REG_LIGHT_MIN:   prdata = 32'(light_min_reg);
            REG_LIGHT_MAX:   prdata = 32'(light_max_reg);
            REG_COUNTS_MAX:  prdata = 32'(counts_max_reg);
            REG_COUNTS_MIN:  prdata = 32'(counts_min_reg);
            REG_AUTO_ENABLE: prdata = 32'(auto_enable_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_min_reg   <= '0;
            light_max_reg   <= '1;
            counts_max_reg  <= '1;
            counts_min_reg  <= '0;
            auto_enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_LIGHT_MIN:   light_min_reg   <= pwdata[SMP_W-1:0];
                REG_LIGHT_MAX:   light_max_reg   <= pwdata[SMP_W-1:0];
                REG_COUNTS_MAX:  counts_max_reg  <= pwdata[CNT_W-1:0];
                REG_COUNTS_MIN:  counts_min_reg  <= pwdata[CNT_W-1:0];
                REG_AUTO_ENABLE: auto_enable_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // interpolation span, the divisor of the slope
    assign range = (light_max_reg >= light_min_reg) ? (light_max_reg - light_min_reg) : '0;

    lbts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && in_op == OP_CAL),
        .dividend (counts_max_reg - counts_min_reg),
        .divisor  (range),
        .res      (div_res)
    );

    assign step = (range != '0) ? div_res.quotient  : '0;
    assign rem  = (range != '0) ? div_res.remainder : '0;

    // table sweep
    assign in_range  = (32'(fill_idx_reg) >= 32'(light_min_reg)) &&
                       (32'(fill_idx_reg) <= 32'(light_max_reg));
    assign fill_last = fill_idx_reg == TBL_AW'(TABLE_DEPTH - 1);
    assign err_sum   = {1'b0, err_reg} + {1'b0, rem};

    always_comb
    begin
        val_next = val_reg;
        err_next = err_reg;
        if (in_range)
        begin
            val_next = val_reg - step;
            err_next = err_sum[SMP_W-1:0];
            if (err_sum >= {1'b0, range})
            begin
                val_next = val_next - 1'b1;
                err_next = SMP_W'(err_sum - {1'b0, range});
            end
        end
        if (in_range)
            mem_wdata = val_reg;
        else if (32'(fill_idx_reg) < 32'(light_min_reg))
            mem_wdata = counts_max_reg;
        else
            mem_wdata = counts_min_reg;
    end

    assign mem_we = (state_reg == ST_FILL);
    assign rd_en  = accept && in_op == OP_SAMPLE && in_ch == CH_LIGHT && auto_enable_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[fill_idx_reg] <= mem_wdata;
        if (rd_en)
            rdata_reg <= mem[table_index(in_smp)];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV)
        begin
            fill_idx_reg <= '0;
            val_reg      <= counts_max_reg;
            err_reg      <= '0;
        end
        else if (state_reg == ST_FILL)
        begin
            fill_idx_reg <= fill_idx_reg + 1'b1;
            val_reg      <= val_next;
            err_reg      <= err_next;
        end
    end

    // 1/64 step toward target
    always_comb
    begin
        if (rdata_reg > bright_reg)
        begin
            diff        = rdata_reg - bright_reg;
            bright_next = bright_reg + (diff >> SHIFT_K);
        end
        else
        begin
            diff        = bright_reg - rdata_reg;
            bright_next = bright_reg - (diff >> SHIFT_K);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (in_op == OP_CAL)
                        state_next = ST_DIV;
                    else if (rd_en)
                        state_next = ST_TRACK;
                    else
                        state_next = ST_DONE;
                end
            ST_DIV:
                if (div_res.done)
                    state_next = ST_FILL;
            ST_FILL:
                if (fill_last)
                    state_next = ST_DONE;
            ST_TRACK:
                state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            therm_reg     <= '0;
            light_reg     <= '0;
            bright_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && in_op == OP_SAMPLE)
            begin
                if (in_ch == CH_THERM)
                    therm_reg <= in_smp;
                else
                    light_reg <= in_smp;
            end
            if (state_reg == ST_TRACK)
                bright_reg <= bright_next;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
            out_data_reg <= M_DATA_W'({bright_reg, light_reg, therm_reg});
    end

endmodule
